>>> hw/rtl/emboss_pkg.sv
// Package for the 3x3 diagonal emboss filter: field widths, register
// indexes, pixel and result types, and the per-channel emboss function.
// No dependencies.
`timescale 1ns / 1ps

package emboss_pkg;

    localparam int CH_W       = 8;
    localparam int CFG_W      = 13;
    localparam int COORD_W    = 12;
    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PW    = 2;
    localparam int FIFO_CW    = 2;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [CFG_W-1:0] DIM_MIN      = 13'd3;
    localparam logic [CH_W-1:0]  CH_MAX       = 8'd255;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [CH_W-1:0] ch2;
        logic [CH_W-1:0] ch1;
        logic [CH_W-1:0] ch0;
    } pix_t;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        pix_t               pix;
    } out_item_t;

    // 2*up_left - centre - down_right, clamped to the 8-bit range
    function automatic logic [CH_W-1:0] emboss_ch(
        input logic [CH_W-1:0] up_left,
        input logic [CH_W-1:0] centre,
        input logic [CH_W-1:0] down_right
    );
        logic signed [CH_W+2:0] v;
        logic [CH_W-1:0]        r;
        v = $signed({2'b00, up_left, 1'b0})
            - $signed({3'b000, centre})
            - $signed({3'b000, down_right});
        if (v < 0) begin
            r = '0;
        end else if (v > $signed({3'b000, CH_MAX})) begin
            r = CH_MAX;
        end else begin
            r = v[CH_W-1:0];
        end
        return r;
    endfunction

    function automatic pix_t emboss_pix(input pix_t ul, input pix_t ce, input pix_t dr);
        pix_t p;
        p.ch0 = emboss_ch(ul.ch0, ce.ch0, dr.ch0);
        p.ch1 = emboss_ch(ul.ch1, ce.ch1, dr.ch1);
        p.ch2 = emboss_ch(ul.ch2, ce.ch2, dr.ch2);
        return p;
    endfunction

endpackage

>>> hw/rtl/emboss_3x3_rgb_filter_top.sv
// Top level of the 3x3 diagonal emboss filter: position counters, two
// line-store memories, delay taps and a small result queue.
// Depends on emboss_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_ready): one RGB pixel per item in raster
//   order; first_of_frame restarts the position at row 0, column 0.
//   Output channel (out_valid / out_ready): one item for each interior
//   pixel, tagged with its row and column. Pixel (r,c) with r>=2 and c>=2
//   releases output (r-1,c-1); border pixels produce no item.
//   Config port (cfg_we, cfg_index, cfg_data): image_width (index 0) and
//   image_height (index 1); values below 3 act as 3, values above
//   MAX_WIDTH / MAX_HEIGHT act as the maximum. Write only while idle.
// Throughput and pipeline
//   One item per clock while in_ready is high. A result is formed in
//   stage 1, where the synchronous line-store read data arrives, and is
//   then loaded into the result queue. The line stores are read at the
//   new column and written back in the following cycle; a write-to-read
//   bypass covers back-to-back items that land on the same column.
// Reset
//   Counters, delay taps, queue and registers (640 x 480) clear at once.
//   The line stores are not cleared; no clearing pass runs.
// Stall
//   A three-entry result queue absorbs the item in flight; in_ready drops
//   only when the queue plus the item in flight would fill it, so the
//   input keeps flowing while a finished result waits to be taken.
module emboss_3x3_rgb_filter_top #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           first_of_frame,
    input  logic [emboss_pkg::CH_W-1:0]    in_ch0,
    input  logic [emboss_pkg::CH_W-1:0]    in_ch1,
    input  logic [emboss_pkg::CH_W-1:0]    in_ch2,

    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [emboss_pkg::COORD_W-1:0] out_row,
    output logic [emboss_pkg::COORD_W-1:0] out_col,
    output logic [emboss_pkg::CH_W-1:0]    out_ch0,
    output logic [emboss_pkg::CH_W-1:0]    out_ch1,
    output logic [emboss_pkg::CH_W-1:0]    out_ch2,

    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [emboss_pkg::CFG_W-1:0]   cfg_data
);

    // Column / row index widths and compare widths
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WW  = (CW + 1 > emboss_pkg::CFG_W) ? CW + 1 : emboss_pkg::CFG_W;
    localparam int HW  = (RW + 1 > emboss_pkg::CFG_W) ? RW + 1 : emboss_pkg::CFG_W;
    localparam int CXW = (CW > emboss_pkg::COORD_W) ? CW : emboss_pkg::COORD_W;
    localparam int RXW = (RW > emboss_pkg::COORD_W) ? RW : emboss_pkg::COORD_W;

    // Configuration
    logic [emboss_pkg::CFG_W-1:0] width_reg;
    logic [emboss_pkg::CFG_W-1:0] height_reg;
    logic [WW-1:0]                w_eff;
    logic [HW-1:0]                h_eff;

    // Position counters
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] c0;
    logic [RW-1:0] r0;
    logic [WW-1:0] c_inc;
    logic [HW-1:0] r_inc;

    // Stage 1: item whose line-store read is in flight
    logic                           s1_valid_reg;
    logic                           s1_emit_reg;
    logic [CW-1:0]                  s1_col_reg;
    emboss_pkg::pix_t               s1_cur_reg;
    logic [emboss_pkg::COORD_W-1:0] s1_orow_reg;
    logic [emboss_pkg::COORD_W-1:0] s1_ocol_reg;
    logic                           s1_fwd_reg;
    emboss_pkg::pix_t               s1_fwd_one_reg;
    emboss_pkg::pix_t               s1_fwd_two_reg;

    // Line stores and their registered read data
    emboss_pkg::pix_t one_mem [MAX_WIDTH];
    emboss_pkg::pix_t two_mem [MAX_WIDTH];
    emboss_pkg::pix_t one_rd_reg;
    emboss_pkg::pix_t two_rd_reg;

    // Diagonal delay taps
    emboss_pkg::pix_t dly_one_reg;
    emboss_pkg::pix_t dly_two_near_reg;
    emboss_pkg::pix_t dly_two_far_reg;

    // Result queue
    emboss_pkg::out_item_t          q_mem_reg [emboss_pkg::FIFO_DEPTH];
    logic [emboss_pkg::FIFO_PW-1:0] q_wr_reg, q_rd_reg;
    logic [emboss_pkg::FIFO_CW-1:0] q_cnt_reg, q_cnt_next;

    logic                  accept;
    logic                  emit0;
    logic                  s1_push;
    logic                  pop;
    logic                  fwd0;
    emboss_pkg::pix_t      cur0;
    emboss_pkg::pix_t      above;
    emboss_pkg::pix_t      above2;
    emboss_pkg::out_item_t s1_item;
    emboss_pkg::out_item_t q_head;
    logic [RXW-1:0]        orow_wide;
    logic [CXW-1:0]        ocol_wide;

    // ------------------------------------------------------------------
    // Effective frame size: clamp the registers into 3..MAX
    // ------------------------------------------------------------------
    always_comb
    begin
        priority if (width_reg < emboss_pkg::DIM_MIN) begin
            w_eff = WW'(emboss_pkg::DIM_MIN);
        end else if (WW'(width_reg) > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_reg);
        end
        priority if (height_reg < emboss_pkg::DIM_MIN) begin
            h_eff = HW'(emboss_pkg::DIM_MIN);
        end else if (HW'(height_reg) > HW'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(height_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            width_reg  <= emboss_pkg::WIDTH_RESET;
            height_reg <= emboss_pkg::HEIGHT_RESET;
        end else if (cfg_we) begin
            unique case (emboss_pkg::reg_index_t'(cfg_index))
                emboss_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                emboss_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: position of the incoming item and next counter values
    // ------------------------------------------------------------------
    assign accept = in_valid && in_ready;
    assign cur0   = '{ch2: in_ch2, ch1: in_ch1, ch0: in_ch0};

    always_comb
    begin
        // restart on first_of_frame; wrap a counter left beyond a shrunk size
        if (first_of_frame || (WW'(col_reg) >= w_eff)) begin
            c0 = '0;
        end else begin
            c0 = col_reg;
        end
        if (first_of_frame || (HW'(row_reg) >= h_eff)) begin
            r0 = '0;
        end else begin
            r0 = row_reg;
        end

        c_inc = WW'(c0) + WW'(1);
        r_inc = HW'(r0) + HW'(1);
        if (c_inc >= w_eff) begin
            col_next = '0;
            if (r_inc >= h_eff) begin
                row_next = '0;
            end else begin
                row_next = r_inc[RW-1:0];
            end
        end else begin
            col_next = c_inc[CW-1:0];
            row_next = r0;
        end

        emit0     = (RXW'(r0) >= RXW'(2)) && (CXW'(c0) >= CXW'(2));
        orow_wide = RXW'(r0) - RXW'(1);
        ocol_wide = CXW'(c0) - CXW'(1);
        // same column as the write-back in flight: bypass the store
        fwd0      = s1_valid_reg && (c0 == s1_col_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: resolve the read data, write back, update the taps
    // ------------------------------------------------------------------
    assign above  = s1_fwd_reg ? s1_fwd_one_reg : one_rd_reg;
    assign above2 = s1_fwd_reg ? s1_fwd_two_reg : two_rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            s1_emit_reg  <= accept && emit0;
            s1_fwd_reg   <= fwd0;
        end
    end

    // Payload of the item in flight; the bypass copies what stage 1 writes
    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_col_reg     <= c0;
            s1_cur_reg     <= cur0;
            s1_orow_reg    <= orow_wide[emboss_pkg::COORD_W-1:0];
            s1_ocol_reg    <= ocol_wide[emboss_pkg::COORD_W-1:0];
            s1_fwd_one_reg <= s1_cur_reg;
            s1_fwd_two_reg <= above;
        end
    end

    // Line stores: read at the new column, write back the older item
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg) begin
            one_mem[s1_col_reg] <= s1_cur_reg;
            two_mem[s1_col_reg] <= above;
        end
        one_rd_reg <= one_mem[c0];
        two_rd_reg <= two_mem[c0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            dly_one_reg      <= '0;
            dly_two_near_reg <= '0;
            dly_two_far_reg  <= '0;
        end else if (s1_valid_reg) begin
            dly_two_far_reg  <= dly_two_near_reg;
            dly_two_near_reg <= above2;
            dly_one_reg      <= above;
        end
    end

    // Result uses the taps from before this item's update
    always_comb
    begin
        s1_item.row = s1_orow_reg;
        s1_item.col = s1_ocol_reg;
        s1_item.pix = emboss_pkg::emboss_pix(dly_two_far_reg, dly_one_reg, s1_cur_reg);
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    assign s1_push   = s1_valid_reg && s1_emit_reg;
    assign out_valid = (q_cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    // hold input when the queue could not take the item in flight plus one more
    assign in_ready  = ({1'b0, q_cnt_reg} + {2'b00, s1_push})
                       < (emboss_pkg::FIFO_CW + 1)'(emboss_pkg::FIFO_DEPTH);

    always_comb
    begin
        priority if (s1_push && !pop) begin
            q_cnt_next = q_cnt_reg + 1'b1;
        end else if (pop && !s1_push) begin
            q_cnt_next = q_cnt_reg - 1'b1;
        end else begin
            q_cnt_next = q_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end else begin
            q_cnt_reg <= q_cnt_next;
            if (s1_push) begin
                q_wr_reg <= (q_wr_reg == emboss_pkg::FIFO_PW'(emboss_pkg::FIFO_DEPTH - 1))
                            ? '0 : q_wr_reg + 1'b1;
            end
            if (pop) begin
                q_rd_reg <= (q_rd_reg == emboss_pkg::FIFO_PW'(emboss_pkg::FIFO_DEPTH - 1))
                            ? '0 : q_rd_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_push) begin
            q_mem_reg[q_wr_reg] <= s1_item;
        end
    end

    assign q_head  = q_mem_reg[q_rd_reg];
    assign out_row = q_head.row;
    assign out_col = q_head.col;
    assign out_ch0 = q_head.pix.ch0;
    assign out_ch1 = q_head.pix.ch1;
    assign out_ch2 = q_head.pix.ch2;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_push && !pop &&
          (q_cnt_reg == emboss_pkg::FIFO_CW'(emboss_pkg::FIFO_DEPTH))))
        else $error("result queue overflow");

    a_bypass_same_col: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_valid_reg && (c0 == s1_col_reg)) |=> s1_fwd_reg)
        else $error("same-column item missed the store bypass");

    a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_row != '0) && (out_col != '0)))
        else $error("border position emitted");

    a_emit_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        s1_emit_reg |-> $past(accept))
        else $error("result without an accepted item");

endmodule

>>> sim/tb_emboss_3x3_rgb_filter_top.sv
// Self-checking testbench for the 3x3 diagonal emboss filter top level.
// Streams pixel items through the filter and compares each emitted result
// against an in-bench predictor. Depends on emboss_pkg and the filter RTL.
`timescale 1ns / 1ps

module tb_emboss_3x3_rgb_filter_top;

    localparam int MAX_W         = 4096;
    localparam int MAX_H         = 4096;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 60;    // long receiver hold-off
    localparam int STALL_LIMIT   = 2000;  // cycles with no item moving on either side
    localparam int RANDOM_ITEMS  = 1450;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic             fof;
        emboss_pkg::pix_t pix;
    } pixel_item_t;

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                           clk            = 1'b0;
    logic                           rst_n          = 1'b0;
    logic                           in_valid       = 1'b0;
    logic                           in_ready;
    logic                           first_of_frame = 1'b0;
    logic [emboss_pkg::CH_W-1:0]    in_ch0         = '0;
    logic [emboss_pkg::CH_W-1:0]    in_ch1         = '0;
    logic [emboss_pkg::CH_W-1:0]    in_ch2         = '0;
    logic                           out_valid;
    logic                           out_ready      = 1'b0;
    logic [emboss_pkg::COORD_W-1:0] out_row;
    logic [emboss_pkg::COORD_W-1:0] out_col;
    logic [emboss_pkg::CH_W-1:0]    out_ch0;
    logic [emboss_pkg::CH_W-1:0]    out_ch1;
    logic [emboss_pkg::CH_W-1:0]    out_ch2;
    logic                           cfg_we         = 1'b0;
    logic                           cfg_index      = 1'b0;
    logic [emboss_pkg::CFG_W-1:0]   cfg_data       = '0;

    // ------------------------------------------------------------------
    // Predictor state: register mirror, line stores, diagonal taps and
    // raster position. The line stores start unknown, like the hardware.
    // ------------------------------------------------------------------
    logic [emboss_pkg::CFG_W-1:0] width_reg  = emboss_pkg::WIDTH_RESET;
    logic [emboss_pkg::CFG_W-1:0] height_reg = emboss_pkg::HEIGHT_RESET;
    emboss_pkg::pix_t             line_one [MAX_W];
    emboss_pkg::pix_t             line_two [MAX_W];
    emboss_pkg::pix_t             tap_one  = '0;
    emboss_pkg::pix_t             tap_near = '0;
    emboss_pkg::pix_t             tap_far  = '0;
    int unsigned                  pos_row  = 0;
    int unsigned                  pos_col  = 0;

    emboss_pkg::out_item_t pending_embossed [$];   // results owed by the filter, oldest first
    pixel_item_t           pixels_to_send [$];     // items waiting for the driver

    int unsigned pix_queued   = 0;
    int unsigned pix_accepted = 0;
    int unsigned results_seen = 0;
    int unsigned err_count    = 0;
    int unsigned cfg_writes   = 0;
    int unsigned stall_cycles = 0;

    // Idling controls for the driver and the receiver
    logic        idle_on   = 1'b1;
    int unsigned hold_asks = 0;
    int unsigned hold_seen = 0;
    int unsigned in_gap    = 0;
    int unsigned rx_gap    = 0;
    int unsigned rx_hold   = 0;
    logic        in_taken  = 1'b0;    // input item moved at the last rising edge

    emboss_3x3_rgb_filter_top #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .first_of_frame (first_of_frame),
        .in_ch0         (in_ch0),
        .in_ch1         (in_ch1),
        .in_ch2         (in_ch2),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_row        (out_row),
        .out_col        (out_col),
        .out_ch0        (out_ch0),
        .out_ch1        (out_ch1),
        .out_ch2        (out_ch2),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Register value as the filter uses it: clamp to 3..top
    function automatic int unsigned dim_in_effect(input logic [emboss_pkg::CFG_W-1:0] raw,
                                                  input int unsigned top);
        if (raw < emboss_pkg::DIM_MIN)
            return emboss_pkg::DIM_MIN;
        if (raw > top)
            return top;
        return raw;
    endfunction

    // 2*up_left - centre - down_right, saturated to one byte
    function automatic logic [emboss_pkg::CH_W-1:0] emboss_sample(
        input logic [emboss_pkg::CH_W-1:0] up_left,
        input logic [emboss_pkg::CH_W-1:0] centre,
        input logic [emboss_pkg::CH_W-1:0] down_right
    );
        int v;
        v = 2 * int'(up_left) - int'(centre) - int'(down_right);
        if (v < 0)
            v = 0;
        else if (v > int'(emboss_pkg::CH_MAX))
            v = int'(emboss_pkg::CH_MAX);
        return v[emboss_pkg::CH_W-1:0];
    endfunction

    // Advance the predictor by one accepted pixel; queue the result it owes
    function automatic void predict_emboss(input logic mark, input emboss_pkg::pix_t cur);
        int unsigned           w;
        int unsigned           h;
        int unsigned           c;
        emboss_pkg::pix_t      above;
        emboss_pkg::pix_t      above2;
        emboss_pkg::out_item_t res;
        w = dim_in_effect(width_reg, MAX_W);
        h = dim_in_effect(height_reg, MAX_H);
        if (mark) begin
            pos_row = 0;
            pos_col = 0;
        end
        // a shrunk register pulls the position back inside the frame
        if (pos_col >= w)
            pos_col = 0;
        if (pos_row >= h)
            pos_row = 0;
        c      = pos_col;
        above  = line_one[c];
        above2 = line_two[c];
        if (pos_row >= 2 && c >= 2) begin
            res.row     = emboss_pkg::COORD_W'(pos_row - 1);
            res.col     = emboss_pkg::COORD_W'(c - 1);
            res.pix.ch0 = emboss_sample(tap_far.ch0, tap_one.ch0, cur.ch0);
            res.pix.ch1 = emboss_sample(tap_far.ch1, tap_one.ch1, cur.ch1);
            res.pix.ch2 = emboss_sample(tap_far.ch2, tap_one.ch2, cur.ch2);
            pending_embossed.push_back(res);
        end
        tap_far     = tap_near;
        tap_near    = above2;
        tap_one     = above;
        line_two[c] = above;
        line_one[c] = cur;
        pos_col     = c + 1;
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
            if (pos_row >= h)
                pos_row = 0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge. Predict first so a
    // result is matched against the oldest owed entry either way.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        emboss_pkg::out_item_t want;
        if (rst_n) begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready) begin
                predict_emboss(first_of_frame, {in_ch2, in_ch1, in_ch0});
                pix_accepted++;
            end
            if (out_valid && out_ready) begin
                results_seen++;
                if (pending_embossed.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("ERROR %0t: unexpected result row %0d col %0d pix %h",
                                 $time, out_row, out_col, {out_ch2, out_ch1, out_ch0});
                end else begin
                    want = pending_embossed.pop_front();
                    if (out_row !== want.row || out_col !== want.col ||
                        out_ch0 !== want.pix.ch0 || out_ch1 !== want.pix.ch1 ||
                        out_ch2 !== want.pix.ch2) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display({"ERROR %0t: mismatch, expected row %0d col %0d pix %h,",
                                      " got row %0d col %0d pix %h"},
                                     $time, want.row, want.col, want.pix,
                                     out_row, out_col, {out_ch2, out_ch1, out_ch0});
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: change inputs at the falling edge. Hold valid and payload
    // until the item is taken; drop valid for short random bursts.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : pixel_driver
        pixel_item_t nxt;
        if (rst_n && !(in_valid && !in_taken)) begin
            if (in_gap != 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                // drop valid now and draw a random idle gap
                in_gap = $urandom_range(0, 2);
                in_valid <= 1'b0;
            end else if (pixels_to_send.size() != 0) begin
                nxt = pixels_to_send.pop_front();
                in_valid       <= 1'b1;
                first_of_frame <= nxt.fof;
                in_ch0         <= nxt.pix.ch0;
                in_ch1         <= nxt.pix.ch1;
                in_ch2         <= nxt.pix.ch2;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random short stalls, plus a long hold-off on request that
    // it counts out itself.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                rx_hold   = HOLD_CYCLES;
            end
            if (rx_hold != 0) begin
                rx_hold--;
                out_ready <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap--;
                out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                rx_gap = $urandom_range(0, 2);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no item moves for too long
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
                if (stall_cycles == STALL_LIMIT) begin
                    $display("ERROR %0t: no progress, %0d pixels unsent, %0d results owed",
                             $time, pix_queued - pix_accepted, pending_embossed.size());
                    $display("Verification failed");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Write one register at the next falling edge; mirror it right away,
    // since the filter is idle whenever this runs
    task automatic write_reg(input emboss_pkg::reg_index_t idx,
                             input logic [emboss_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == emboss_pkg::REG_IMAGE_WIDTH)
            width_reg = val;
        else
            height_reg = val;
        cfg_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Block until every queued pixel is taken and every result has come,
    // then let the pipeline settle
    task automatic wait_drained();
        while (pix_accepted != pix_queued || pending_embossed.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic queue_pixel(input logic mark, input emboss_pkg::pix_t p);
        pixels_to_send.push_back('{fof: mark, pix: p});
        pix_queued++;
    endtask

    // Bias channels toward 0 and 255 so both clamps are hit often
    function automatic emboss_pkg::pix_t rand_pixel();
        emboss_pkg::pix_t p;
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 5))
                0:       p[k*emboss_pkg::CH_W +: emboss_pkg::CH_W] = '0;
                1:       p[k*emboss_pkg::CH_W +: emboss_pkg::CH_W] = emboss_pkg::CH_MAX;
                default: p[k*emboss_pkg::CH_W +: emboss_pkg::CH_W] =
                             emboss_pkg::CH_W'($urandom_range(0, 255));
            endcase
        end
        return p;
    endfunction

    // Queue a run of random pixels; noisy runs drop a stray frame mark now and then
    task automatic queue_frame(input logic mark_first, input int unsigned count,
                               input logic noisy);
        for (int unsigned i = 0; i < count; i++)
            queue_pixel((i == 0) ? mark_first : (noisy && $urandom_range(0, 99) == 0),
                        rand_pixel());
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        emboss_pkg::pix_t             demo_frame [16];
        logic [emboss_pkg::CFG_W-1:0] w_raw;
        logic [emboss_pkg::CFG_W-1:0] h_raw;
        int unsigned                  w_eff;
        int unsigned                  h_eff;
        int unsigned                  cur_w_eff;
        int unsigned                  rows;
        int unsigned                  npix;
        int unsigned                  nframes;
        int unsigned                  phase;
        int unsigned                  random_end;
        logic                         start_mark;

        // 4x4 frame, raster order, {ch2, ch1, ch0}. The diagonal pixels are
        // picked so that the four results saturate high, saturate low and
        // land on exact mid-range values across the channels.
        demo_frame = '{24'hC800FF, 24'hFFFFFF, 24'h7F8001, 24'h123456,
                       24'h000000, 24'h96FF00, 24'h000000, 24'hABCDEF,
                       24'h55AA55, 24'hFFFFFF, 24'h32FF00, 24'h000000,
                       24'hAA55AA, 24'h0F0F0F, 24'hFFFFFF, 24'h0100FF};

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Directed: a 4x4 frame with hand-picked diagonal pixels
        write_reg(emboss_pkg::REG_IMAGE_WIDTH, 13'd4);
        write_reg(emboss_pkg::REG_IMAGE_HEIGHT, 13'd4);
        foreach (demo_frame[i])
            queue_pixel(i == 0, demo_frame[i]);
        wait_drained();

        // Directed: register values below the minimum act as 3x3
        write_reg(emboss_pkg::REG_IMAGE_WIDTH, 13'd0);
        write_reg(emboss_pkg::REG_IMAGE_HEIGHT, 13'd1);
        queue_frame(1'b1, 9, 1'b0);
        wait_drained();

        // Directed: all-ones registers act as the maximum size, so a short
        // run stays on the first row and owes no result
        write_reg(emboss_pkg::REG_IMAGE_WIDTH, '1);
        write_reg(emboss_pkg::REG_IMAGE_HEIGHT, '1);
        queue_frame(1'b1, 24, 1'b0);
        wait_drained();

        // Directed: an 8x6 frame with the receiver held off, so the result
        // queue fills and the input stalls
        write_reg(emboss_pkg::REG_IMAGE_WIDTH, 13'd8);
        write_reg(emboss_pkg::REG_IMAGE_HEIGHT, 13'd6);
        queue_frame(1'b1, 48, 1'b0);
        hold_asks++;
        cur_w_eff = 8;

        // Random phases: new register settings each phase, mostly whole
        // frames with random content, some cut short and some stray marks.
        random_end = pix_queued + RANDOM_ITEMS;
        phase      = 0;
        while (pix_queued < random_end) begin
            wait_drained();
            // no idling in the tail of the run, and now and then a phase without it
            idle_on = (pix_queued + 250 < random_end) && ($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 9))
                0:       w_raw = emboss_pkg::CFG_W'($urandom_range(0, 2));
                1:       w_raw = emboss_pkg::CFG_W'($urandom_range(13, 40));
                default: w_raw = emboss_pkg::CFG_W'($urandom_range(3, 12));
            endcase
            case ($urandom_range(0, 9))
                0:       h_raw = emboss_pkg::CFG_W'($urandom_range(0, 2));
                1:       h_raw = emboss_pkg::CFG_W'($urandom_range(MAX_H + 1,
                                                                   2 ** emboss_pkg::CFG_W - 1));
                default: h_raw = emboss_pkg::CFG_W'($urandom_range(3, 7));
            endcase
            write_reg(emboss_pkg::REG_IMAGE_WIDTH, w_raw);
            write_reg(emboss_pkg::REG_IMAGE_HEIGHT, h_raw);
            w_eff = dim_in_effect(w_raw, MAX_W);
            h_eff = dim_in_effect(h_raw, MAX_H);
            // A wider row would read line-store columns that the current
            // frame never wrote: restart the frame. Otherwise the old frame
            // may carry on under the new size.
            start_mark = (w_eff > cur_w_eff) || ($urandom_range(0, 3) != 0);
            cur_w_eff  = w_eff;
            nframes    = $urandom_range(1, 3);
            for (int f = 0; f < nframes; f++) begin
                rows = (h_eff > 8) ? $urandom_range(3, 6) : h_eff;
                npix = w_eff * rows;
                if ($urandom_range(0, 7) == 0)
                    npix = $urandom_range(1, npix - 1);
                queue_frame((f == 0) ? start_mark : 1'($urandom_range(0, 1)), npix, 1'b1);
                if (f == 0 && idle_on && phase % 5 == 1)
                    hold_asks++;
                // pause the sender until the filter has emptied, mid-phase
                if (f == 0 && idle_on && phase % 7 == 3)
                    wait_drained();
            end
            phase++;
        end

        wait_drained();
        $display("Run covered %0d pixels and %0d register writes over %0d phases;",
                 pix_accepted, cfg_writes, phase + 4);
        $display("%0d embossed results checked, %0d errors", results_seen, err_count);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/emboss_pkg.sv
hw/rtl/emboss_3x3_rgb_filter_top.sv
sim/tb_emboss_3x3_rgb_filter_top.sv
